// File: hdl/kpc_pkg.sv
// Shared types and constants of the keypad press classifier.
`default_nettype none

package kpc_pkg;

  // Input item kinds as they arrive on the command port.
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_RESET = 2'd2
  } kind_e;

  // Operations after classification by the front end.
  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Reported actions.
  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_FIRST      = 3'd1,
    ACT_SHORT_HOLD = 3'd2,
    ACT_SHORT_REL  = 3'd3,
    ACT_LONG_HOLD  = 3'd4,
    ACT_LONG_REL   = 3'd5
  } action_e;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_SHORT_TIME = 2'd0,
    REG_LONG_TIME  = 2'd1,
    REG_LONG_MODE  = 2'd2
  } reg_e;

  // Event flag bits of one key.
  localparam logic [4:0] FL_FIRST      = 5'b00001;
  localparam logic [4:0] FL_SHORT_HOLD = 5'b00010;
  localparam logic [4:0] FL_SHORT_REL  = 5'b00100;
  localparam logic [4:0] FL_LONG_HOLD  = 5'b01000;
  localparam logic [4:0] FL_LONG_REL   = 5'b10000;

  // Reset values of the thresholds.
  localparam logic [15:0] SHORT_TIME_RST = 16'd20;
  localparam logic [15:0] LONG_TIME_RST  = 16'd1000;

  // Key field and mask widths fixed by the interface.
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned MAX_KEY_W = 6;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One classified command.
  typedef struct packed {
    op_e         op;
    logic [15:0] levels;
    logic [7:0]  ms;
    logic [3:0]  idx;
  } cmd_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic [15:0] short_time;
    logic [15:0] long_time;
    logic [15:0] long_mode_mask;
  } cfg_t;

  // One stored key entry.
  typedef struct packed {
    logic [15:0] timer;
    logic [4:0]  flags;
  } entry_t;

endpackage

`default_nettype wire

// File: hdl/kpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/kpc_cfg.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module kpc_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output kpc_pkg::cfg_t      cfg_o
);

  import kpc_pkg::*;

  logic [15:0] short_q;
  logic [15:0] long_q;
  logic [15:0] mode_q;
  logic        wr_en;
  reg_e        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_e'(paddr[3:2]);

  // Register writes; an address past the last register is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= SHORT_TIME_RST;
      long_q  <= LONG_TIME_RST;
      mode_q  <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SHORT_TIME: short_q <= pwdata[15:0];
        REG_LONG_TIME:  long_q  <= pwdata[15:0];
        REG_LONG_MODE:  mode_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (reg_sel)
      REG_SHORT_TIME: prdata = {16'd0, short_q};
      REG_LONG_TIME:  prdata = {16'd0, long_q};
      REG_LONG_MODE:  prdata = {16'd0, mode_q};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = '{short_time: short_q, long_time: long_q, long_mode_mask: mode_q};

endmodule

`default_nettype wire

// File: hdl/kpc_front.sv
// Front end: accepts command words and classifies them for the back end.
`default_nettype none

module kpc_front #(
  parameter int unsigned NUM_KEYS = 16
) (
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   kind_i,
  input  wire logic [15:0]  key_levels_i,
  input  wire logic [7:0]   tick_ms_i,
  input  wire logic [3:0]   key_index_i,
  input  wire logic         queue_full_i,
  output logic              push_o,
  output kpc_pkg::cmd_t     cmd_o
);

  import kpc_pkg::*;

  logic  key_in_range;
  kind_e kind;

  assign busy         = queue_full_i;
  assign push_o       = start & ~queue_full_i;
  assign kind         = kind_e'(kind_i);
  assign key_in_range = {3'd0, key_index_i} < 7'(NUM_KEYS);

  // Classify the word; reads and resets of absent keys and the unused kind do nothing.
  always_comb begin
    cmd_o.levels = key_levels_i;
    cmd_o.ms     = tick_ms_i;
    cmd_o.idx    = key_index_i;
    case (kind)
      KIND_TICK:  cmd_o.op = OP_TICK;
      KIND_READ:  cmd_o.op = key_in_range ? OP_READ : OP_NOP;
      KIND_RESET: cmd_o.op = key_in_range ? OP_CLEAR : OP_NOP;
      default:    cmd_o.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/kpc_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module kpc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire kpc_pkg::cmd_t push_data_i,
  input  wire logic          pop_i,
  output kpc_pkg::cmd_t      head_o,
  output logic               full_o,
  output logic               empty_o
);

  import kpc_pkg::*;

  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [QW-1:0] wptr_q;
  logic [QW-1:0] rptr_q;
  logic [CW-1:0] count_q;
  logic          do_push;
  logic          do_pop;

  assign full_o  = count_q == CW'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rptr_q];

  // Storage of the queued words.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(wptr_q + 1'b1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(rptr_q + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= CW'(count_q + 1'b1);
        2'b01:   count_q <= CW'(count_q - 1'b1);
        default: ;
      endcase
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // A pop on an empty queue is never requested.
  a_no_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: hdl/kpc_back.sv
// Back end: walks the key table for ticks and serves reads and key resets.
`default_nettype none

module kpc_back #(
  parameter int unsigned NUM_KEYS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire kpc_pkg::cfg_t cfg_i,
  input  wire kpc_pkg::cmd_t head_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               done_o,
  output logic [2:0]         action_o,
  output logic [15:0]        pending_mask_o
);

  import kpc_pkg::*;

  localparam int unsigned KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_KEY
  } state_e;

  state_e        state_q, state_d;
  logic [KW-1:0] idx_q, idx_d;
  op_e           op_q, op_d;
  logic [15:0]   levels_q, levels_d;
  logic [7:0]    ms_q, ms_d;
  logic          done_q, done_d;
  action_e       action_q, action_d;
  logic [15:0]   mask_q, mask_d;

  logic [NUM_KEYS-1:0] entry_valid_q, entry_valid_d;
  logic [NUM_KEYS-1:0] pending_q, pending_d;

  logic          re;
  logic [KW-1:0] raddr;
  logic          we;
  entry_t        rd_data;
  entry_t        cur;
  entry_t        nxt;
  action_e       act;
  logic [MAX_KEY_W-1:0] idx_wide;
  logic          key_on;
  logic          long_mode;
  logic [16:0]   sum;
  logic [15:0]   sat;
  logic [15:0]   vis_mask;

  // Timer and flags of every key.
  kpc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_KEYS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q),
    .wdata_i (nxt),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  // Key level and mode bit; keys past sixteen are always open and in short mode.
  assign idx_wide  = MAX_KEY_W'(idx_q);
  assign key_on    = (idx_wide < MAX_KEY_W'(LEVEL_W)) && levels_q[idx_wide[3:0]];
  assign long_mode = (idx_wide < MAX_KEY_W'(LEVEL_W)) &&
                     cfg_i.long_mode_mask[idx_wide[3:0]];

  // Entry update for the current key; an entry never written reads as zero.
  always_comb begin
    cur = entry_valid_q[idx_q] ? rd_data : '0;
    nxt = cur;
    act = ACT_NONE;
    sum = {1'b0, cur.timer} + {9'd0, ms_q};
    sat = sum[16] ? 16'hFFFF : sum[15:0];
    case (op_q)
      OP_TICK: begin
        if (cur.timer < cfg_i.short_time) begin
          nxt.timer = key_on ? sat : '0;
        end else if (cur.flags == '0) begin
          nxt.flags = FL_FIRST | FL_SHORT_HOLD;
        end else if (!long_mode) begin
          if (key_on) begin
            nxt.flags = cur.flags | FL_SHORT_HOLD;
          end else begin
            nxt.timer = '0;
            nxt.flags = cur.flags | FL_SHORT_REL;
          end
        end else if (cur.timer < cfg_i.long_time) begin
          if (key_on) begin
            nxt.timer = sat;
          end else begin
            nxt.timer = '0;
            nxt.flags = cur.flags | FL_SHORT_REL;
          end
        end else begin
          if (key_on) begin
            nxt.flags = cur.flags | FL_LONG_HOLD;
          end else begin
            nxt.timer = '0;
            nxt.flags = cur.flags | FL_LONG_REL;
          end
        end
      end
      OP_READ: begin
        // Highest-priority pending event; holds persist until a later event is pending.
        if ((cur.flags & FL_FIRST) != '0) begin
          act       = ACT_FIRST;
          nxt.flags = cur.flags & ~FL_FIRST;
        end else if ((cur.flags & FL_SHORT_HOLD) != '0) begin
          act = ACT_SHORT_HOLD;
          if ((cur.flags & (FL_SHORT_REL | FL_LONG_REL | FL_LONG_HOLD)) != '0) begin
            nxt.flags = cur.flags & ~FL_SHORT_HOLD;
          end
        end else if ((cur.flags & FL_LONG_HOLD) != '0) begin
          act = ACT_LONG_HOLD;
          if ((cur.flags & (FL_SHORT_REL | FL_LONG_REL)) != '0) begin
            nxt.flags = cur.flags & ~FL_LONG_HOLD;
          end
        end else if ((cur.flags & (FL_SHORT_REL | FL_LONG_REL)) != '0) begin
          act       = ((cur.flags & FL_SHORT_REL) != '0) ? ACT_SHORT_REL : ACT_LONG_REL;
          nxt.flags = '0;
        end
      end
      OP_CLEAR: begin
        nxt = '0;
      end
      default: ;
    endcase
  end

  // Per-key valid and pending bits follow each table write.
  always_comb begin
    entry_valid_d = entry_valid_q;
    pending_d     = pending_q;
    if (we) begin
      entry_valid_d[idx_q] = 1'b1;
      pending_d[idx_q]     = nxt.flags != '0;
    end
  end

  // Only the first sixteen keys show in the pending mask.
  for (genvar k = 0; k < LEVEL_W; k++) begin : g_mask
    if (k < NUM_KEYS) begin : g_key
      assign vis_mask[k] = pending_d[k];
    end else begin : g_none
      assign vis_mask[k] = 1'b0;
    end
  end

  // Sequencer: one key per cycle for a tick; a read or key reset updates its key in S_KEY.
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    op_d     = op_q;
    levels_d = levels_q;
    ms_d     = ms_q;
    done_d   = 1'b0;
    action_d = action_q;
    mask_d   = mask_q;
    pop_o    = 1'b0;
    re       = 1'b0;
    raddr    = idx_q;
    we       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          op_d     = head_i.op;
          levels_d = head_i.levels;
          ms_d     = head_i.ms;
          case (head_i.op)
            OP_TICK: begin
              re      = 1'b1;
              raddr   = '0;
              idx_d   = '0;
              state_d = S_TICK;
            end
            OP_READ, OP_CLEAR: begin
              re      = 1'b1;
              raddr   = KW'(head_i.idx);
              idx_d   = KW'(head_i.idx);
              state_d = S_KEY;
            end
            default: begin
              done_d   = 1'b1;
              action_d = ACT_NONE;
              mask_d   = vis_mask;
            end
          endcase
        end
      end
      S_TICK: begin
        we = 1'b1;
        if (idx_q == KW'(NUM_KEYS - 1)) begin
          done_d   = 1'b1;
          action_d = ACT_NONE;
          mask_d   = vis_mask;
          state_d  = S_IDLE;
        end else begin
          idx_d = KW'(idx_q + 1'b1);
          re    = 1'b1;
          raddr = KW'(idx_q + 1'b1);
        end
      end
      S_KEY: begin
        we       = 1'b1;
        done_d   = 1'b1;
        action_d = act;
        mask_d   = vis_mask;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, per-key bits and the result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      op_q          <= OP_NOP;
      levels_q      <= '0;
      ms_q          <= '0;
      done_q        <= 1'b0;
      action_q      <= ACT_NONE;
      mask_q        <= '0;
      entry_valid_q <= '0;
      pending_q     <= '0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      op_q          <= op_d;
      levels_q      <= levels_d;
      ms_q          <= ms_d;
      done_q        <= done_d;
      action_q      <= action_d;
      mask_q        <= mask_d;
      entry_valid_q <= entry_valid_d;
      pending_q     <= pending_d;
    end
  end

  assign done_o         = done_q;
  assign action_o       = action_q;
  assign pending_mask_o = mask_q;

  // The last key of a tick walk produces a result on the next cycle.
  a_tick_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK && idx_q == KW'(NUM_KEYS - 1)) |=> (done_q && state_q == S_IDLE))
    else $error("tick walk ended without a result");

  // Only a read reports an event; tick results always carry no action.
  a_action_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && action_q != ACT_NONE) |-> $past(state_q == S_KEY && op_q == OP_READ))
    else $error("event reported by an item that is not a read");

endmodule

`default_nettype wire

// File: hdl/keypad_press_classifier.sv
// Top level of the keypad press classifier.
//
// Command channel: a word (kind_i, key_levels_i, tick_ms_i, key_index_i) is taken
// at a rising edge where start is high and busy is low. A tick word brings the
// sampled levels of all keys and the milliseconds since the previous tick; a read
// word returns a key's highest-priority pending event and clears it unless it is
// a hold with no later event; a reset word clears one key's timer and flags.
// Result channel: every word yields one result, shown on action_o and
// pending_mask_o for exactly one cycle while done_o is high. The receiver cannot
// stall; results are produced in word order.
// An accepted word passes through the queue to the back end, which registers the
// result once its table updates are written; a word that does nothing is answered
// straight from the queue. The back end walks the key table one key per cycle
// through a RAM with separate read and write ports and takes no new word until it
// is through with the last. A two-word queue lets the next word be accepted while
// the back end works; busy is high while that queue is full.
// Reset clears all timers, event flags and the queue at once, with no clearing
// pass, and loads the thresholds with their default values. Configuration is
// written through the APB-style port at byte addresses 0, 4 and 8.
`default_nettype none

module keypad_press_classifier #(
  parameter int unsigned NUM_KEYS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   kind_i,
  input  wire logic [15:0]  key_levels_i,
  input  wire logic [7:0]   tick_ms_i,
  input  wire logic [3:0]   key_index_i,
  output logic              done_o,
  output logic [2:0]        action_o,
  output logic [15:0]       pending_mask_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);

  import kpc_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  // Threshold and mode registers.
  kpc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Command acceptance and classification.
  kpc_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .key_levels_i (key_levels_i),
    .tick_ms_i    (tick_ms_i),
    .key_index_i  (key_index_i),
    .queue_full_i (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Queue between front and back.
  kpc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .full_o      (full),
    .empty_o     (empty)
  );

  // Key table walker and result register.
  kpc_back #(
    .NUM_KEYS (NUM_KEYS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .head_i         (head_cmd),
    .empty_i        (empty),
    .pop_o          (pop),
    .done_o         (done_o),
    .action_o       (action_o),
    .pending_mask_o (pending_mask_o)
  );

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the keypad press classifier: command words, results and APB setup.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kpc_pkg::*;

  localparam int NKEYS = 16;
  // The package names no member for the fourth kind code; the block must ignore it.
  localparam logic [1:0] KIND_SPARE = 2'd3;
  // Cycles with no word moving in either direction before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet cycles after the last result, above the longest tick latency.
  localparam int DRAIN_CYCLES = 2 * NKEYS + 8;

  typedef struct packed {
    action_e     action;
    logic [15:0] pending;
  } result_t;

  // One row of the directed table. Rows with a typed-in result carry it in res.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] levels;
    logic [7:0]  ms;
    logic [3:0]  idx;
    logic        typed;
    result_t     res;
  } dir_row_t;

  // One threshold setting and the shape of the random words run under it.
  typedef struct packed {
    logic [15:0] short_t;
    logic [15:0] long_t;
    logic [15:0] mode_mask;
    logic [15:0] words;
    logic [7:0]  ms_hi;
    logic [7:0]  tick_pct;
    logic        hold_key0;
    logic        no_gaps;
  } phase_t;

  localparam int NDIR = 24;
  localparam dir_row_t DIRECTED [0:NDIR-1] = '{
    '{KIND_READ,  16'h0000, 8'h00, 4'h0, 1'b1, '{ACT_NONE, 16'h0000}},
    '{KIND_SPARE, 16'hFFFF, 8'hFF, 4'hF, 1'b1, '{ACT_NONE, 16'h0000}},
    '{KIND_RESET, 16'hFFFF, 8'hFF, 4'hF, 1'b1, '{ACT_NONE, 16'h0000}},
    '{KIND_TICK,  16'hFFFF, 8'hFF, 4'h0, 1'b1, '{ACT_NONE, 16'h0000}},
    '{KIND_TICK,  16'hFFFF, 8'h00, 4'h0, 1'b0, '0},
    '{KIND_READ,  16'h0000, 8'h00, 4'h0, 1'b0, '0},
    '{KIND_READ,  16'hFFFF, 8'hFF, 4'h0, 1'b0, '0},
    '{KIND_TICK,  16'h0000, 8'h01, 4'h0, 1'b0, '0},
    '{KIND_READ,  16'h0000, 8'h00, 4'h0, 1'b0, '0},
    '{KIND_READ,  16'h0000, 8'h00, 4'h0, 1'b0, '0},
    '{KIND_READ,  16'h0000, 8'h00, 4'h0, 1'b0, '0},
    '{KIND_RESET, 16'h0000, 8'h00, 4'h5, 1'b0, '0},
    '{KIND_TICK,  16'h0001, 8'h1E, 4'h0, 1'b0, '0},
    '{KIND_TICK,  16'h0001, 8'h05, 4'h0, 1'b0, '0},
    '{KIND_TICK,  16'h0000, 8'h08, 4'h0, 1'b0, '0},
    '{KIND_TICK,  16'h0002, 8'h19, 4'hA, 1'b0, '0},
    '{KIND_TICK,  16'h0002, 8'h01, 4'h0, 1'b0, '0},
    '{KIND_READ,  16'h0000, 8'h00, 4'h1, 1'b0, '0},
    '{KIND_TICK,  16'h5555, 8'hAA, 4'h0, 1'b0, '0},
    '{KIND_TICK,  16'hAAAA, 8'h55, 4'h0, 1'b0, '0},
    '{KIND_READ,  16'h0000, 8'h00, 4'hF, 1'b0, '0},
    '{KIND_RESET, 16'h0000, 8'h00, 4'h1, 1'b0, '0},
    '{KIND_SPARE, 16'h0000, 8'h00, 4'h0, 1'b0, '0},
    '{KIND_READ,  16'h5A5A, 8'h3C, 4'h7, 1'b0, '0}
  };

  localparam int NPHASE = 5;
  localparam phase_t PHASES [0:NPHASE-1] = '{
    '{16'd20,    16'd1000,  16'h0000, 16'd200, 8'd40,  8'd55, 1'b0, 1'b0},
    '{16'd35,    16'd180,   16'h5A3C, 16'd250, 8'd60,  8'd55, 1'b0, 1'b1},
    '{16'd0,     16'd0,     16'hFFFF, 16'd150, 8'd20,  8'd55, 1'b0, 1'b0},
    '{16'hFFFF,  16'hFFFF,  16'hAAAA, 16'd360, 8'd255, 8'd90, 1'b1, 1'b0},
    '{16'd1,     16'd2,     16'h0F0F, 16'd100, 8'd3,   8'd55, 1'b0, 1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  kind_i;
  logic [15:0] key_levels_i;
  logic [7:0]  tick_ms_i;
  logic [3:0]  key_index_i;
  logic        done_o;
  logic [2:0]  action_o;
  logic [15:0] pending_mask_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Model state: one timer and one flag set per key, plus the thresholds.
  logic [15:0] key_timer [NKEYS];
  logic [4:0]  key_flags [NKEYS];
  logic [15:0] cfg_short;
  logic [15:0] cfg_long;
  logic [15:0] cfg_long_mask;
  logic [15:0] model_pending;

  result_t     expected_q [$];
  int          errors;
  int          words_sent;
  int          results_seen;
  int          reg_writes;
  int          idle_cycles;
  int          act_seen [8];
  logic        gaps_on;

  keypad_press_classifier #(
    .NUM_KEYS(NKEYS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .key_levels_i  (key_levels_i),
    .tick_ms_i     (tick_ms_i),
    .key_index_i   (key_index_i),
    .done_o        (done_o),
    .action_o      (action_o),
    .pending_mask_o(pending_mask_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Timer addition that sticks at the top of its range.
  function automatic logic [15:0] timer_add(logic [15:0] t, logic [7:0] ms);
    logic [16:0] s;
    s = {1'b0, t} + {9'b0, ms};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // Applies one accepted command word to the model and returns the result it yields.
  function automatic result_t classify_word(logic [1:0] kind, logic [15:0] levels,
                                            logic [7:0] ms, logic [3:0] idx);
    result_t     res;
    logic [15:0] t;
    logic [4:0]  f;
    logic        on;
    int          k;
    res.action  = ACT_NONE;
    res.pending = '0;
    case (kind)
      KIND_TICK: begin
        for (k = 0; k < NKEYS; k++) begin
          t  = key_timer[k];
          f  = key_flags[k];
          on = levels[k];
          if (t < cfg_short) begin
            t = on ? timer_add(t, ms) : '0;
          end else if (f == '0) begin
            f = FL_FIRST | FL_SHORT_HOLD;
          end else if (!cfg_long_mask[k]) begin
            if (on) begin
              f |= FL_SHORT_HOLD;
            end else begin
              t = '0;
              f |= FL_SHORT_REL;
            end
          end else if (t < cfg_long) begin
            if (on) begin
              t = timer_add(t, ms);
            end else begin
              t = '0;
              f |= FL_SHORT_REL;
            end
          end else begin
            if (on) begin
              f |= FL_LONG_HOLD;
            end else begin
              t = '0;
              f |= FL_LONG_REL;
            end
          end
          key_timer[k] = t;
          key_flags[k] = f;
        end
      end
      KIND_READ: begin
        // Highest priority first; hold flags survive a read until a later event is pending.
        f = key_flags[idx];
        if ((f & FL_FIRST) != '0) begin
          res.action = ACT_FIRST;
          f &= ~FL_FIRST;
        end else if ((f & FL_SHORT_HOLD) != '0) begin
          res.action = ACT_SHORT_HOLD;
          if ((f & (FL_SHORT_REL | FL_LONG_REL | FL_LONG_HOLD)) != '0) f &= ~FL_SHORT_HOLD;
        end else if ((f & FL_LONG_HOLD) != '0) begin
          res.action = ACT_LONG_HOLD;
          if ((f & (FL_SHORT_REL | FL_LONG_REL)) != '0) f &= ~FL_LONG_HOLD;
        end else if ((f & (FL_SHORT_REL | FL_LONG_REL)) != '0) begin
          res.action = ((f & FL_SHORT_REL) != '0) ? ACT_SHORT_REL : ACT_LONG_REL;
          f = '0;
        end
        key_flags[idx] = f;
      end
      KIND_RESET: begin
        key_flags[idx] = '0;
        key_timer[idx] = '0;
      end
      default: ;
    endcase
    for (k = 0; k < NKEYS; k++) res.pending[k] = (key_flags[k] != '0);
    model_pending = res.pending;
    return res;
  endfunction

  // Sends one command word, with an optional random gap before it, and records its result.
  task automatic send_word(input logic [1:0] kind, input logic [15:0] levels,
                           input logic [7:0] ms, input logic [3:0] idx,
                           input logic typed, input result_t typed_res);
    result_t model;
    if (gaps_on && $urandom_range(99) < 37) begin
      start <= 1'b0;
      repeat ($urandom_range(24, 1)) @(posedge clk_i);
    end
    start        <= 1'b1;
    kind_i       <= kind;
    key_levels_i <= levels;
    tick_ms_i    <= ms;
    key_index_i  <= idx;
    do @(posedge clk_i); while (busy);
    model = classify_word(kind, levels, ms, idx);
    expected_q.push_back(typed ? typed_res : model);
    words_sent++;
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes one threshold register, then reads it back over the same port.
  task automatic reg_write(input reg_e r, input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {16'h0000, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (r)
      REG_SHORT_TIME: cfg_short = v;
      REG_LONG_TIME:  cfg_long = v;
      REG_LONG_MODE:  cfg_long_mask = v;
      default: ;
    endcase
    reg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== v) begin
      $display("%0t: register %s read back, expected %h, actual %h",
               $time, r.name(), v, prdata[15:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result checker: every strobed word is matched against the oldest expectation.
  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected, actual action %0d mask %h",
                 $time, action_o, pending_mask_o);
        errors++;
      end else begin
        exp_res = expected_q.pop_front();
        results_seen++;
        act_seen[action_o]++;
        if (action_o !== exp_res.action) begin
          $display("%0t: action mismatch, expected %0d, actual %0d",
                   $time, exp_res.action, action_o);
          errors++;
        end
        if (pending_mask_o !== exp_res.pending) begin
          $display("%0t: pending mask mismatch, expected %h, actual %h",
                   $time, exp_res.pending, pending_mask_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: a run in which no word moves for too long has hung.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (start && !busy) || done_o === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, nothing moved for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, expected_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    phase_t      ph;
    logic [15:0] held;
    logic [15:0] flips;
    logic [1:0]  kind;
    logic [15:0] levels;
    logic [7:0]  ms;
    logic [3:0]  idx;
    int          n_dir;
    int          p;
    int          n;
    int          b;

    errors        = 0;
    words_sent    = 0;
    results_seen  = 0;
    reg_writes    = 0;
    idle_cycles   = 0;
    foreach (act_seen[i]) act_seen[i] = 0;
    foreach (key_timer[i]) begin
      key_timer[i] = '0;
      key_flags[i] = '0;
    end
    cfg_short     = SHORT_TIME_RST;
    cfg_long      = LONG_TIME_RST;
    cfg_long_mask = '0;
    model_pending = '0;
    held          = '0;
    gaps_on       = 1'b1;

    rst_ni       <= 1'b0;
    start        <= 1'b0;
    kind_i       <= KIND_TICK;
    key_levels_i <= '0;
    tick_ms_i    <= '0;
    key_index_i  <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset thresholds.
    for (n = 0; n < NDIR; n++) begin
      send_word(DIRECTED[n].kind, DIRECTED[n].levels, DIRECTED[n].ms, DIRECTED[n].idx,
                DIRECTED[n].typed, DIRECTED[n].res);
    end
    n_dir = words_sent;

    // Random words, one threshold setting per phase. Keys are held over several
    // ticks so that presses run through the short and long thresholds.
    for (p = 0; p < NPHASE; p++) begin
      ph = PHASES[p];
      drain_results();
      reg_write(REG_SHORT_TIME, ph.short_t);
      reg_write(REG_LONG_TIME, ph.long_t);
      reg_write(REG_LONG_MODE, ph.mode_mask);
      gaps_on = !ph.no_gaps;
      for (n = 0; n < ph.words; n++) begin
        levels = 16'($urandom());
        ms     = 8'($urandom());
        idx    = 4'($urandom_range(15));
        if ($urandom_range(99) < ph.tick_pct) begin
          kind  = KIND_TICK;
          flips = '0;
          for (b = 0; b < 16; b++) flips[b] = ($urandom_range(7) == 0);
          held ^= flips;
          if (ph.hold_key0) held[0] = 1'b1;
          levels = held;
          if (ph.hold_key0) begin
            ms = 8'($urandom_range(255, 240));
          end else if ($urandom_range(9) != 0) begin
            ms = 8'($urandom_range(ph.ms_hi));
          end
        end else begin
          b = $urandom_range(99);
          if (b < 60) begin
            kind = KIND_READ;
            // Mostly read keys that have something pending.
            if (model_pending != '0 && $urandom_range(9) < 7) begin
              do idx = 4'($urandom_range(15)); while (!model_pending[idx]);
            end
          end else if (b < 85) begin
            kind = KIND_RESET;
            // Leave the held key alone so its timer can run into saturation.
            if (ph.hold_key0) idx = 4'($urandom_range(15, 1));
          end else begin
            kind = KIND_SPARE;
          end
        end
        send_word(kind, levels, ms, idx, 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d command words (%0d directed) across %0d threshold settings,",
             words_sent, n_dir, NPHASE + 1);
    $display("%0d register writes; checked %0d results.", reg_writes, results_seen);
    $display("Actions none/first/short hold/short rel/long hold/long rel = %0d/%0d/%0d/%0d/%0d/%0d.",
             act_seen[ACT_NONE], act_seen[ACT_FIRST], act_seen[ACT_SHORT_HOLD],
             act_seen[ACT_SHORT_REL], act_seen[ACT_LONG_HOLD], act_seen[ACT_LONG_REL]);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hdl/kpc_pkg.sv
hdl/kpc_ram.sv
hdl/kpc_cfg.sv
hdl/kpc_front.sv
hdl/kpc_queue.sv
hdl/kpc_back.sv
hdl/keypad_press_classifier.sv
dv/tb_top.sv
